// ----- sv/ole_pkg.sv -----
// ole_pkg: shared types and constants for the ordered list engine
// widths of the stream fields, request modes, result status codes, sequencer states
// no dependencies
package ole_pkg;

    localparam int CAPACITY = 256;

    localparam int MODE_W  = 4;
    localparam int POS_W   = 9;
    localparam int VALUE_W = 32;
    localparam int COPY_W  = 9;
    localparam int STAT_W  = 2;
    localparam int LEN_W   = 9;

    localparam int IN_BITS  = MODE_W + POS_W + 2 * VALUE_W + COPY_W;
    localparam int IN_W     = ((IN_BITS + 7) / 8) * 8;
    localparam int OUT_BITS = STAT_W + 1 + VALUE_W + LEN_W;
    localparam int OUT_W    = ((OUT_BITS + 7) / 8) * 8;

    typedef enum logic [MODE_W-1:0] {
        MODE_TAIL    = 4'd0,
        MODE_HEAD    = 4'd1,
        MODE_AFTER   = 4'd2,
        MODE_AT      = 4'd3,
        MODE_DEL_POS = 4'd4,
        MODE_DEL_KEY = 4'd5,
        MODE_DEDUP   = 4'd6,
        MODE_FIND    = 4'd7,
        MODE_READ    = 4'd8,
        MODE_WRITE   = 4'd9,
        MODE_REPLACE = 4'd10,
        MODE_CLEAR   = 4'd11
    } ole_mode_t;

    typedef enum logic [STAT_W-1:0] {
        STAT_DONE    = 2'd0,
        STAT_IGNORED = 2'd1,
        STAT_FULL    = 2'd2
    } ole_status_t;

    typedef enum logic [3:0] {
        ST_IDLE,
        ST_SCAN_RD,
        ST_SCAN_EV,
        ST_SHR_RD,
        ST_SHR_WR,
        ST_FILL,
        ST_SHL_RD,
        ST_SHL_WR,
        ST_DD_RDI,
        ST_DD_LATI,
        ST_DD_RDK,
        ST_DD_CMP,
        ST_READ,
        ST_DONE
    } ole_state_t;

    typedef struct packed {
        logic [LEN_W-1:0]   len;
        logic [VALUE_W-1:0] rv;
        logic               found;
        ole_status_t        status;
    } ole_res_t;

endpackage

// ----- sv/ole_ram.sv -----
// ole_ram: generic single write port, single read port memory
// registered read data; no reset on the array
// no dependencies
module ole_ram #(
    parameter int WIDTH = 32,
    parameter int DEPTH = 256,
    parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic             re,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ----- sv/ole_ctrl.sv -----
// ole_ctrl: sequencer for the ordered list engine
// walks the element memory one word at a time through a shared key compare
// depends on ole_pkg
module ole_ctrl #(
    parameter int CAPACITY = ole_pkg::CAPACITY,
    parameter int AW       = (CAPACITY > 1) ? $clog2(CAPACITY) : 1
) (
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         start,
    input  logic [ole_pkg::MODE_W-1:0]   mode,
    input  logic [ole_pkg::POS_W-1:0]    position,
    input  logic [ole_pkg::VALUE_W-1:0]  match_key,
    input  logic [ole_pkg::VALUE_W-1:0]  new_value,
    input  logic [ole_pkg::COPY_W-1:0]   copies,
    output logic                         ready,
    input  logic                         out_free,
    output logic                         done,
    output ole_pkg::ole_res_t            res,
    output logic                         ram_we,
    output logic [AW-1:0]                ram_waddr,
    output logic [ole_pkg::VALUE_W-1:0]  ram_wdata,
    output logic                         ram_re,
    output logic [AW-1:0]                ram_raddr,
    input  logic [ole_pkg::VALUE_W-1:0]  ram_rdata
);

    localparam int CW = $clog2(CAPACITY + 1);
    localparam int XW = ((CW > ole_pkg::POS_W) ? CW : ole_pkg::POS_W) + 1;

    ole_pkg::ole_state_t  state_reg, state_next;
    ole_pkg::ole_mode_t   mode_reg, mode_next;
    ole_pkg::ole_status_t status_reg, status_next;
    logic [ole_pkg::VALUE_W-1:0] key_reg, key_next;
    logic [ole_pkg::VALUE_W-1:0] val_reg, val_next;
    logic [ole_pkg::VALUE_W-1:0] cand_reg, cand_next;
    logic [ole_pkg::VALUE_W-1:0] rv_reg, rv_next;
    logic [CW-1:0] cnt_reg, cnt_next;
    logic [CW-1:0] i_reg, i_next;
    logic [CW-1:0] w_reg, w_next;
    logic [CW-1:0] k_reg, k_next;
    logic [CW-1:0] at_reg, at_next;
    logic [CW-1:0] e_reg, e_next;
    logic          hit_reg, hit_next;
    logic          found_reg, found_next;

    logic [XW-1:0] pos_x, cnt_x, cpy_x, cap_x;
    logic          full, pos_lt, pos_gt, eq;
    logic [ole_pkg::VALUE_W-1:0] cmp_ref;
    ole_pkg::ole_mode_t in_mode;

    assign in_mode = ole_pkg::ole_mode_t'(mode);
    assign pos_x   = XW'(position);
    assign cnt_x   = XW'(cnt_reg);
    assign cpy_x   = XW'(copies);
    assign cap_x   = XW'(CAPACITY);
    assign full    = (cnt_x == cap_x);
    assign pos_lt  = (pos_x < cnt_x);
    assign pos_gt  = (pos_x > cnt_x);

    // shared compare unit
    assign cmp_ref = (state_reg == ole_pkg::ST_DD_CMP) ? cand_reg : key_reg;
    assign eq      = (ram_rdata == cmp_ref);

    assign ready = (state_reg == ole_pkg::ST_IDLE);
    assign done  = (state_reg == ole_pkg::ST_DONE) && out_free;
    assign res.status = status_reg;
    assign res.found  = found_reg;
    assign res.rv     = rv_reg;
    assign res.len    = ole_pkg::LEN_W'(cnt_reg);

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            ole_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    case (in_mode)
                        ole_pkg::MODE_TAIL, ole_pkg::MODE_HEAD:
                            state_next = full ? ole_pkg::ST_DONE : ole_pkg::ST_SHR_RD;
                        ole_pkg::MODE_AFTER, ole_pkg::MODE_DEL_KEY,
                        ole_pkg::MODE_FIND, ole_pkg::MODE_REPLACE:
                            state_next = ole_pkg::ST_SCAN_RD;
                        ole_pkg::MODE_AT:
                        begin
                            if (pos_gt || (cpy_x > cap_x - cnt_x) || (copies == '0))
                                state_next = ole_pkg::ST_DONE;
                            else
                                state_next = ole_pkg::ST_SHR_RD;
                        end
                        ole_pkg::MODE_DEL_POS:
                            state_next = pos_lt ? ole_pkg::ST_SHL_RD : ole_pkg::ST_DONE;
                        ole_pkg::MODE_DEDUP:
                            state_next = ole_pkg::ST_DD_RDI;
                        ole_pkg::MODE_READ:
                            state_next = pos_lt ? ole_pkg::ST_READ : ole_pkg::ST_DONE;
                        default:
                            state_next = ole_pkg::ST_DONE;
                    endcase
                end
            end
            ole_pkg::ST_SCAN_RD:
                state_next = (i_reg == cnt_reg) ? ole_pkg::ST_DONE : ole_pkg::ST_SCAN_EV;
            ole_pkg::ST_SCAN_EV:
            begin
                state_next = ole_pkg::ST_SCAN_RD;
                if (eq && mode_reg == ole_pkg::MODE_FIND)
                    state_next = ole_pkg::ST_DONE;
                if (eq && mode_reg == ole_pkg::MODE_AFTER)
                    state_next = full ? ole_pkg::ST_DONE : ole_pkg::ST_SHR_RD;
            end
            ole_pkg::ST_SHR_RD:
                state_next = (i_reg == at_reg) ? ole_pkg::ST_FILL : ole_pkg::ST_SHR_WR;
            ole_pkg::ST_SHR_WR:
                state_next = ole_pkg::ST_SHR_RD;
            ole_pkg::ST_FILL:
                state_next = (i_reg + 1'b1 == e_reg) ? ole_pkg::ST_DONE : ole_pkg::ST_FILL;
            ole_pkg::ST_SHL_RD:
                state_next = (i_reg >= cnt_reg) ? ole_pkg::ST_DONE : ole_pkg::ST_SHL_WR;
            ole_pkg::ST_SHL_WR:
                state_next = ole_pkg::ST_SHL_RD;
            ole_pkg::ST_DD_RDI:
                state_next = (i_reg == cnt_reg) ? ole_pkg::ST_DONE : ole_pkg::ST_DD_LATI;
            ole_pkg::ST_DD_LATI:
                state_next = ole_pkg::ST_DD_RDK;
            ole_pkg::ST_DD_RDK:
                state_next = (k_reg == w_reg) ? ole_pkg::ST_DD_RDI : ole_pkg::ST_DD_CMP;
            ole_pkg::ST_DD_CMP:
                state_next = eq ? ole_pkg::ST_DD_RDI : ole_pkg::ST_DD_RDK;
            ole_pkg::ST_READ:
                state_next = ole_pkg::ST_DONE;
            ole_pkg::ST_DONE:
                state_next = out_free ? ole_pkg::ST_IDLE : ole_pkg::ST_DONE;
            default:
                state_next = ole_pkg::ST_IDLE;
        endcase
    end

    // datapath registers
    always_comb
    begin
        mode_next   = mode_reg;
        status_next = status_reg;
        key_next    = key_reg;
        val_next    = val_reg;
        cand_next   = cand_reg;
        rv_next     = rv_reg;
        cnt_next    = cnt_reg;
        i_next      = i_reg;
        w_next      = w_reg;
        k_next      = k_reg;
        at_next     = at_reg;
        e_next      = e_reg;
        hit_next    = hit_reg;
        found_next  = found_reg;
        case (state_reg)
            ole_pkg::ST_IDLE:
            begin
                if (start)
                begin
                    mode_next   = in_mode;
                    key_next    = match_key;
                    val_next    = new_value;
                    status_next = ole_pkg::STAT_DONE;
                    found_next  = 1'b0;
                    rv_next     = '0;
                    hit_next    = 1'b0;
                    i_next      = '0;
                    w_next      = '0;
                    case (in_mode)
                        ole_pkg::MODE_TAIL:
                        begin
                            if (full)
                                status_next = ole_pkg::STAT_FULL;
                            at_next = cnt_reg;
                            e_next  = cnt_reg + 1'b1;
                            i_next  = cnt_reg;
                        end
                        ole_pkg::MODE_HEAD:
                        begin
                            if (full)
                                status_next = ole_pkg::STAT_FULL;
                            at_next = '0;
                            e_next  = CW'(1);
                            i_next  = cnt_reg;
                        end
                        ole_pkg::MODE_AT:
                        begin
                            if (pos_gt)
                                status_next = ole_pkg::STAT_IGNORED;
                            else if (cpy_x > cap_x - cnt_x)
                                status_next = ole_pkg::STAT_FULL;
                            at_next = CW'(position);
                            e_next  = CW'(position) + CW'(copies);
                            i_next  = cnt_reg;
                        end
                        ole_pkg::MODE_DEL_POS:
                        begin
                            if (!pos_lt)
                                status_next = ole_pkg::STAT_IGNORED;
                            i_next = CW'(position) + 1'b1;
                        end
                        ole_pkg::MODE_READ, ole_pkg::MODE_WRITE:
                        begin
                            if (!pos_lt)
                                status_next = ole_pkg::STAT_IGNORED;
                        end
                        ole_pkg::MODE_AFTER, ole_pkg::MODE_DEL_KEY, ole_pkg::MODE_FIND,
                        ole_pkg::MODE_REPLACE, ole_pkg::MODE_DEDUP:
                        begin
                        end
                        ole_pkg::MODE_CLEAR:
                            cnt_next = '0;
                        default:
                            status_next = ole_pkg::STAT_IGNORED;
                    endcase
                end
            end
            ole_pkg::ST_SCAN_RD:
            begin
                if (i_reg == cnt_reg)
                begin
                    case (mode_reg)
                        ole_pkg::MODE_DEL_KEY:
                        begin
                            status_next = (w_reg == cnt_reg) ? ole_pkg::STAT_IGNORED
                                                             : ole_pkg::STAT_DONE;
                            cnt_next = w_reg;
                        end
                        ole_pkg::MODE_REPLACE:
                            status_next = hit_reg ? ole_pkg::STAT_DONE : ole_pkg::STAT_IGNORED;
                        default:
                            status_next = ole_pkg::STAT_IGNORED;
                    endcase
                end
            end
            ole_pkg::ST_SCAN_EV:
            begin
                i_next = i_reg + 1'b1;
                case (mode_reg)
                    ole_pkg::MODE_AFTER:
                    begin
                        if (eq)
                        begin
                            if (full)
                                status_next = ole_pkg::STAT_FULL;
                            at_next = i_reg + 1'b1;
                            e_next  = i_reg + CW'(2);
                            i_next  = cnt_reg;
                        end
                    end
                    ole_pkg::MODE_FIND:
                    begin
                        if (eq)
                        begin
                            found_next = 1'b1;
                            rv_next    = ram_rdata;
                        end
                    end
                    ole_pkg::MODE_DEL_KEY:
                    begin
                        if (!eq)
                            w_next = w_reg + 1'b1;
                    end
                    ole_pkg::MODE_REPLACE:
                    begin
                        if (eq)
                            hit_next = 1'b1;
                    end
                    default:
                    begin
                    end
                endcase
            end
            ole_pkg::ST_SHR_WR:
                i_next = i_reg - 1'b1;
            ole_pkg::ST_FILL:
            begin
                i_next = i_reg + 1'b1;
                if (i_reg + 1'b1 == e_reg)
                    cnt_next = cnt_reg + (e_reg - at_reg);
            end
            ole_pkg::ST_SHL_RD:
            begin
                if (i_reg >= cnt_reg)
                    cnt_next = cnt_reg - 1'b1;
            end
            ole_pkg::ST_SHL_WR:
                i_next = i_reg + 1'b1;
            ole_pkg::ST_DD_RDI:
            begin
                if (i_reg == cnt_reg)
                    cnt_next = w_reg;
            end
            ole_pkg::ST_DD_LATI:
            begin
                cand_next = ram_rdata;
                k_next    = '0;
            end
            ole_pkg::ST_DD_RDK:
            begin
                if (k_reg == w_reg)
                begin
                    w_next = w_reg + 1'b1;
                    i_next = i_reg + 1'b1;
                end
            end
            ole_pkg::ST_DD_CMP:
            begin
                if (eq)
                    i_next = i_reg + 1'b1;
                else
                    k_next = k_reg + 1'b1;
            end
            ole_pkg::ST_READ:
            begin
                found_next = 1'b1;
                rv_next    = ram_rdata;
            end
            default:
            begin
            end
        endcase
    end

    // memory port control
    always_comb
    begin
        ram_we    = 1'b0;
        ram_waddr = '0;
        ram_wdata = val_reg;
        ram_re    = 1'b0;
        ram_raddr = '0;
        case (state_reg)
            ole_pkg::ST_IDLE:
            begin
                ram_re    = start;
                ram_raddr = AW'(position);
                if (start && in_mode == ole_pkg::MODE_WRITE && pos_lt)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(position);
                    ram_wdata = new_value;
                end
            end
            ole_pkg::ST_SCAN_RD, ole_pkg::ST_SHL_RD, ole_pkg::ST_DD_RDI:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(i_reg);
            end
            ole_pkg::ST_SCAN_EV:
            begin
                if (mode_reg == ole_pkg::MODE_DEL_KEY && !eq)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(w_reg);
                    ram_wdata = ram_rdata;
                end
                if (mode_reg == ole_pkg::MODE_REPLACE && eq)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(i_reg);
                end
            end
            ole_pkg::ST_SHR_RD:
            begin
                ram_re    = 1'b1;
                ram_raddr = AW'(i_reg - 1'b1);
            end
            ole_pkg::ST_SHR_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(i_reg - 1'b1 + (e_reg - at_reg));
                ram_wdata = ram_rdata;
            end
            ole_pkg::ST_FILL:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(i_reg);
            end
            ole_pkg::ST_SHL_WR:
            begin
                ram_we    = 1'b1;
                ram_waddr = AW'(i_reg - 1'b1);
                ram_wdata = ram_rdata;
            end
            ole_pkg::ST_DD_RDK:
            begin
                if (k_reg == w_reg)
                begin
                    ram_we    = 1'b1;
                    ram_waddr = AW'(w_reg);
                    ram_wdata = cand_reg;
                end
                else
                begin
                    ram_re    = 1'b1;
                    ram_raddr = AW'(k_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ole_pkg::ST_IDLE;
            cnt_reg   <= '0;
        end
        else
        begin
            state_reg <= state_next;
            cnt_reg   <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        mode_reg   <= mode_next;
        status_reg <= status_next;
        key_reg    <= key_next;
        val_reg    <= val_next;
        cand_reg   <= cand_next;
        rv_reg     <= rv_next;
        i_reg      <= i_next;
        w_reg      <= w_next;
        k_reg      <= k_next;
        at_reg     <= at_next;
        e_reg      <= e_next;
        hit_reg    <= hit_next;
        found_reg  <= found_next;
    end

endmodule

// ----- sv/ordered_list_engine_unit.sv -----
// a write, clear or rejected request goes from idle straight to done, a read via one read
// state; scans test one element at a time, inserts shift elements up and then write each
// copy, dedup tests each element against the kept ones; one request at a time; a finished
// word waits in the output register while the next request is taken
// reset: asynchronous, clears the element count; the element memory is not cleared
module ordered_list_engine_unit #(
    parameter int CAPACITY = ole_pkg::CAPACITY
) (
    input  logic                       clk,
    input  logic                       rst_n,
    input  logic                       s_tvalid,
    output logic                       s_tready,
    // mode, position, match_key, new_value, copies, zero pad
    input  logic [ole_pkg::IN_W-1:0]   s_tdata,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    // status, found, read_value, list_length, zero pad
    output logic [ole_pkg::OUT_W-1:0]  m_tdata
);

    localparam int AW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
    localparam int P0 = ole_pkg::MODE_W;
    localparam int P1 = P0 + ole_pkg::POS_W;
    localparam int P2 = P1 + ole_pkg::VALUE_W;
    localparam int P3 = P2 + ole_pkg::VALUE_W;

    logic                        start, ready, done, out_free;
    logic                        ram_we, ram_re;
    logic [AW-1:0]               ram_waddr, ram_raddr;
    logic [ole_pkg::VALUE_W-1:0] ram_wdata, ram_rdata;
    ole_pkg::ole_res_t           res;
    ole_pkg::ole_res_t           out_reg;
    logic                        out_valid_reg;

    assign s_tready = ready;
    assign start    = s_tvalid && ready;
    assign out_free = !out_valid_reg || m_tready;

    ole_ctrl #(
        .CAPACITY (CAPACITY),
        .AW       (AW)
    ) u_ctrl (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (start),
        .mode      (s_tdata[P0-1:0]),
        .position  (s_tdata[P1-1:P0]),
        .match_key (s_tdata[P2-1:P1]),
        .new_value (s_tdata[P3-1:P2]),
        .copies    (s_tdata[P3+ole_pkg::COPY_W-1:P3]),
        .ready     (ready),
        .out_free  (out_free),
        .done      (done),
        .res       (res),
        .ram_we    (ram_we),
        .ram_waddr (ram_waddr),
        .ram_wdata (ram_wdata),
        .ram_re    (ram_re),
        .ram_raddr (ram_raddr),
        .ram_rdata (ram_rdata)
    );

    ole_ram #(
        .WIDTH (ole_pkg::VALUE_W),
        .DEPTH (CAPACITY),
        .AW    (AW)
    ) u_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (ram_waddr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (ram_raddr),
        .rdata (ram_rdata)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (done)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (done)
        begin
            out_reg <= res;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = ole_pkg::OUT_W'(out_reg);

endmodule

// ----- sv/ole_checker.sv -----
// ole_checker: port level checks for the ordered list engine
// bound to ordered_list_engine_unit; depends on ole_pkg
module ole_checker #(
    parameter int CAPACITY = ole_pkg::CAPACITY
) (
    input logic                      clk,
    input logic                      rst_n,
    input logic                      s_tvalid,
    input logic                      s_tready,
    input logic                      m_tvalid,
    input logic                      m_tready,
    input logic [ole_pkg::OUT_W-1:0] m_tdata
);

    localparam int LB = ole_pkg::STAT_W + 1 + ole_pkg::VALUE_W;

    // one word in flight: no accept on the cycle after an accept
    a_one_at_a_time: assert property (@(posedge clk) disable iff (!rst_n)
        (s_tvalid && s_tready) |=> !s_tready)
        else $error("input accepted while busy");

    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
        else $error("output word dropped or changed");

    a_found_status: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && m_tdata[ole_pkg::STAT_W])
        |-> (m_tdata[ole_pkg::STAT_W-1:0] == ole_pkg::STAT_DONE))
        else $error("found with non-done status");

    a_value_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (m_tvalid && !m_tdata[ole_pkg::STAT_W]) |-> (m_tdata[LB-1:ole_pkg::STAT_W+1] == '0))
        else $error("read value without find");

    a_length: assert property (@(posedge clk) disable iff (!rst_n)
        m_tvalid |-> (m_tdata[LB+ole_pkg::LEN_W-1:LB] <= ole_pkg::LEN_W'(CAPACITY)))
        else $error("length above capacity");

endmodule

bind ordered_list_engine_unit ole_checker #(
    .CAPACITY (CAPACITY)
) u_ole_checker (
    .clk      (clk),
    .rst_n    (rst_n),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
);
